// ===== hdl/fba_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package fba_pkg;

  localparam int unsigned FRAME_W   = 20;
  localparam int unsigned WORD_W    = 32;
  localparam int unsigned BIT_W     = 5;
  localparam int unsigned WIU_W     = 8;
  localparam int unsigned RSV_W     = 32;
  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned CFG_DAT_W = 32;
  localparam int unsigned STAT_W    = 2;
  localparam int unsigned LIVE_W    = 16;
  localparam int unsigned CNT_W     = 21;
  localparam int unsigned PAGE_SH   = 12;

  localparam logic [RSV_W:0] PAGE_ROUND = (RSV_W + 1)'(32'h0000_0FFF);
  localparam logic [WIU_W-1:0] WIU_RESET = WIU_W'(128);

  typedef enum logic [1:0] {
    OP_INIT     = 2'd0,
    OP_ALLOC    = 2'd1,
    OP_ALLOC_AT = 2'd2,
    OP_FREE     = 2'd3
  } fba_op_e;

  localparam logic [STAT_W-1:0] ST_DONE  = 2'd0;
  localparam logic [STAT_W-1:0] ST_SKIP  = 2'd1;
  localparam logic [STAT_W-1:0] ST_EMPTY = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_WORDS_IN_USE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_RESERVED_END = 1'b1;

endpackage

`default_nettype wire

// ===== hdl/fba_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none

module fba_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 128,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

// ===== hdl/frame_bitmap_allocator.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Init writes every one of the BITMAP_WORDS words in turn; alloc reads words from the
// first, at most up to clamped words_in_use, and sets the first free bit it finds;
// alloc-at and free update one word, none for mapped alloc, unmapped free, out of range.
// One request at a time; a new one is taken after the result register loads.
// After reset a clearing pass writes zero to all BITMAP_WORDS words, one per cycle, and
// holds off requests meanwhile; configuration resets to 128 words in use, reserved end 0.
module frame_bitmap_allocator #(
  parameter int unsigned BITMAP_WORDS = 128
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             cfg_we_i,
  input  wire logic [fba_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  wire logic [fba_pkg::CFG_DAT_W-1:0]    cfg_data_i,
  input  wire logic                             in_valid_i,
  output logic                                  in_stall_o,
  input  wire logic [1:0]                       operation_i,
  input  wire logic [fba_pkg::FRAME_W-1:0]      page_frame_i,
  input  wire logic [fba_pkg::FRAME_W-1:0]      target_frame_i,
  output logic                                  out_valid_o,
  input  wire logic                             out_stall_i,
  output logic [fba_pkg::STAT_W-1:0]            status_o,
  output logic [fba_pkg::FRAME_W-1:0]           frame_number_o
);
  import fba_pkg::*;

  localparam int unsigned WIDX = (BITMAP_WORDS > 1) ? $clog2(BITMAP_WORDS) : 1;
  localparam int unsigned CW   = $clog2(BITMAP_WORDS + 1);
  localparam logic [WIDX-1:0]   LAST_WORD = WIDX'(BITMAP_WORDS - 1);
  localparam logic [LIVE_W-1:0] MAX_LIVE  = LIVE_W'(BITMAP_WORDS);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_INIT,
    S_SCAN,
    S_FOUND,
    S_RMW,
    S_DONE
  } state_e;

  logic [WIU_W-1:0] wiu_q;
  logic [RSV_W-1:0] rsv_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wiu_q <= WIU_RESET;
      rsv_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_WORDS_IN_USE: wiu_q <= cfg_data_i[WIU_W-1:0];
        CFG_RESERVED_END: rsv_q <= cfg_data_i[RSV_W-1:0];
        default: ;
      endcase
    end
  end

  state_e                 state_q, state_d;
  fba_op_e                op_q, op_d;
  logic [FRAME_W-1:0]     frm_q, frm_d;
  logic [WIDX-1:0]        sw_q, sw_d;
  logic [CW-1:0]          iss_q, iss_d;
  logic                   chk_vld_q, chk_vld_d;
  logic [WIDX-1:0]        chk_idx_q, chk_idx_d;
  logic [WIDX-1:0]        wadr_q, wadr_d;
  logic [WORD_W-1:0]      wdat_q, wdat_d;
  logic [STAT_W-1:0]      res_st_q, res_st_d;
  logic [FRAME_W-1:0]     res_frm_q, res_frm_d;
  logic                   out_vld_q, out_vld_d;
  logic [STAT_W-1:0]      out_st_q, out_st_d;
  logic [FRAME_W-1:0]     out_frm_q, out_frm_d;

  logic                   ram_we;
  logic [WIDX-1:0]        ram_waddr;
  logic [WORD_W-1:0]      ram_wdata;
  logic [WIDX-1:0]        ram_raddr;
  logic [WORD_W-1:0]      ram_rdata;

  logic [LIVE_W-1:0]      live;
  logic [FRAME_W-1:0]     in_frm;
  logic                   in_inrange;
  logic                   frm_inrange;
  logic                   accept;
  logic                   issuing;
  logic [CNT_W-1:0]       count;
  logic [CNT_W-1:0]       base;
  logic [CNT_W-1:0]       diff;
  logic [WORD_W-1:0]      init_word;
  logic [BIT_W-1:0]       free_bit;
  logic [WORD_W-1:0]      bit_mask;

  fba_ram #(
    .WIDTH (WORD_W),
    .DEPTH (BITMAP_WORDS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign live = (LIVE_W'(wiu_q) > MAX_LIVE) ? MAX_LIVE : LIVE_W'(wiu_q);

  assign in_frm      = (fba_op_e'(operation_i) == OP_FREE) ? page_frame_i : target_frame_i;
  assign in_inrange  = LIVE_W'(in_frm[FRAME_W-1:BIT_W]) < live;
  assign frm_inrange = LIVE_W'(frm_q[FRAME_W-1:BIT_W]) < live;

  assign accept  = in_valid_i && !in_stall_o;
  assign issuing = LIVE_W'(iss_q) < live;

  assign count = CNT_W'((({1'b0, rsv_q}) + PAGE_ROUND) >> PAGE_SH);
  assign base  = {{(CNT_W - BIT_W - WIDX){1'b0}}, sw_q, {BIT_W{1'b0}}};
  assign diff  = count - base;

  always_comb begin
    init_word = '0;
    if (LIVE_W'(sw_q) < live) begin
      if (count >= base + CNT_W'(WORD_W)) begin
        init_word = '1;
      end else if (count > base) begin
        init_word = ~({WORD_W{1'b1}} << diff[BIT_W-1:0]);
      end
    end
  end

  always_comb begin
    free_bit = '0;
    for (int i = WORD_W - 1; i >= 0; i--) begin
      if (!wdat_q[i]) begin
        free_bit = BIT_W'(i);
      end
    end
  end

  assign bit_mask = WORD_W'(1) << frm_q[BIT_W-1:0];

  always_comb begin
    ram_raddr = in_frm[BIT_W +: WIDX];
    if (state_q == S_SCAN) begin
      ram_raddr = iss_q[WIDX-1:0];
    end
  end

  always_comb begin
    state_d   = state_q;
    op_d      = op_q;
    frm_d     = frm_q;
    sw_d      = sw_q;
    iss_d     = iss_q;
    chk_vld_d = 1'b0;
    chk_idx_d = chk_idx_q;
    wadr_d    = wadr_q;
    wdat_d    = wdat_q;
    res_st_d  = res_st_q;
    res_frm_d = res_frm_q;
    out_vld_d = out_vld_q && out_stall_i;
    out_st_d  = out_st_q;
    out_frm_d = out_frm_q;
    ram_we    = 1'b0;
    ram_waddr = sw_q;
    ram_wdata = '0;

    case (state_q)
      S_CLEAR: begin
        ram_we = 1'b1;
        sw_d   = sw_q + WIDX'(1);
        if (sw_q == LAST_WORD) begin
          sw_d    = '0;
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          op_d      = fba_op_e'(operation_i);
          frm_d     = in_frm;
          res_st_d  = ST_DONE;
          res_frm_d = '0;
          case (fba_op_e'(operation_i))
            OP_INIT: begin
              sw_d    = '0;
              state_d = S_INIT;
            end
            OP_ALLOC: begin
              if (page_frame_i != '0) begin
                res_st_d = ST_SKIP;
                state_d  = S_DONE;
              end else begin
                iss_d   = '0;
                state_d = S_SCAN;
              end
            end
            OP_ALLOC_AT: begin
              if (in_inrange) begin
                state_d = S_RMW;
              end else begin
                res_frm_d = target_frame_i;
                state_d   = S_DONE;
              end
            end
            OP_FREE: begin
              if (page_frame_i == '0) begin
                res_st_d = ST_SKIP;
                state_d  = S_DONE;
              end else if (in_inrange) begin
                state_d = S_RMW;
              end else begin
                res_frm_d = page_frame_i;
                state_d   = S_DONE;
              end
            end
            default: state_d = S_IDLE;
          endcase
        end
      end
      S_INIT: begin
        ram_we    = 1'b1;
        ram_wdata = init_word;
        sw_d      = sw_q + WIDX'(1);
        if (sw_q == LAST_WORD) begin
          sw_d    = '0;
          state_d = S_DONE;
        end
      end
      S_SCAN: begin
        if (chk_vld_q && (ram_rdata != '1)) begin
          wadr_d  = chk_idx_q;
          wdat_d  = ram_rdata;
          state_d = S_FOUND;
        end else if (!chk_vld_q && !issuing) begin
          res_st_d = ST_EMPTY;
          state_d  = S_DONE;
        end else if (issuing) begin
          chk_vld_d = 1'b1;
          chk_idx_d = iss_q[WIDX-1:0];
          iss_d     = iss_q + CW'(1);
        end
      end
      S_FOUND: begin
        ram_we    = 1'b1;
        ram_waddr = wadr_q;
        ram_wdata = wdat_q | (WORD_W'(1) << free_bit);
        res_frm_d = {(FRAME_W - BIT_W)'(wadr_q), free_bit};
        state_d   = S_DONE;
      end
      S_RMW: begin
        ram_waddr = frm_q[BIT_W +: WIDX];
        if (op_q == OP_FREE) begin
          ram_we    = frm_inrange;
          ram_wdata = ram_rdata & ~bit_mask;
          res_frm_d = frm_q;
        end else if ((ram_rdata & bit_mask) != '0) begin
          res_st_d = ST_SKIP;
        end else begin
          ram_we    = frm_inrange;
          ram_wdata = ram_rdata | bit_mask;
          res_frm_d = frm_q;
        end
        state_d = S_DONE;
      end
      S_DONE: begin
        if (!out_vld_q || !out_stall_i) begin
          out_vld_d = 1'b1;
          out_st_d  = res_st_q;
          out_frm_d = res_frm_q;
          state_d   = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_CLEAR;
      op_q      <= OP_INIT;
      frm_q     <= '0;
      sw_q      <= '0;
      iss_q     <= '0;
      chk_vld_q <= 1'b0;
      chk_idx_q <= '0;
      wadr_q    <= '0;
      wdat_q    <= '0;
      res_st_q  <= ST_DONE;
      res_frm_q <= '0;
      out_vld_q <= 1'b0;
      out_st_q  <= ST_DONE;
      out_frm_q <= '0;
    end else begin
      state_q   <= state_d;
      op_q      <= op_d;
      frm_q     <= frm_d;
      sw_q      <= sw_d;
      iss_q     <= iss_d;
      chk_vld_q <= chk_vld_d;
      chk_idx_q <= chk_idx_d;
      wadr_q    <= wadr_d;
      wdat_q    <= wdat_d;
      res_st_q  <= res_st_d;
      res_frm_q <= res_frm_d;
      out_vld_q <= out_vld_d;
      out_st_q  <= out_st_d;
      out_frm_q <= out_frm_d;
    end
  end

  assign in_stall_o     = (state_q != S_IDLE);
  assign out_valid_o    = out_vld_q;
  assign status_o       = out_st_q;
  assign frame_number_o = out_frm_q;

endmodule

`default_nettype wire

// ===== hdl/fba_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none

module fba_checker (
  input wire logic                        clk_i,
  input wire logic                        rst_ni,
  input wire logic                        in_valid_i,
  input wire logic                        in_stall_o,
  input wire logic                        out_valid_o,
  input wire logic                        out_stall_i,
  input wire logic [fba_pkg::STAT_W-1:0]  status_o,
  input wire logic [fba_pkg::FRAME_W-1:0] frame_number_o
);
  import fba_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(status_o) && $stable(frame_number_o))
    else $error("stalled result changed");

  a_busy_after_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("request taken while previous one in flight");

  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (status_o == ST_DONE || status_o == ST_SKIP || status_o == ST_EMPTY))
    else $error("bad status code");

  a_zero_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o != ST_DONE) |-> frame_number_o == '0)
    else $error("nonzero frame on skip or empty");

endmodule

bind frame_bitmap_allocator fba_checker u_fba_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_valid_i),
  .in_stall_o     (in_stall_o),
  .out_valid_o    (out_valid_o),
  .out_stall_i    (out_stall_i),
  .status_o       (status_o),
  .frame_number_o (frame_number_o)
);

`default_nettype wire

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps

module tb;
  import fba_pkg::*;

  localparam int unsigned MAP_WORDS = 128;
  localparam int unsigned SETTLE = MAP_WORDS + 12;
  localparam int unsigned QUIET_LIMIT = 4000;
  localparam int unsigned PRINT_LIMIT = 50;
  localparam logic [FRAME_W-1:0] FRAME_MAX = '1;

  typedef struct packed {
    fba_op_e            op;
    logic [FRAME_W-1:0] page;
    logic [FRAME_W-1:0] target;
  } frame_req_t;

  typedef struct packed {
    logic [STAT_W-1:0]  status;
    logic [FRAME_W-1:0] frame;
  } frame_res_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx = '0;
  logic [CFG_DAT_W-1:0] cfg_data = '0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic [1:0]           operation = '0;
  logic [FRAME_W-1:0]   page_frame = '0;
  logic [FRAME_W-1:0]   target_frame = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [STAT_W-1:0]    status;
  logic [FRAME_W-1:0]   frame_number;

  frame_req_t        request_q[$];
  frame_res_t        outcome_q[$];
  frame_req_t        cur_req;
  logic [WORD_W-1:0] used_map [MAP_WORDS];
  logic [WIU_W-1:0]  words_reg = WIU_RESET;
  logic [RSV_W-1:0]  reserved_reg = '0;
  bit                calm = 1'b1;
  int unsigned       send_gap = 0;
  int unsigned       take_wait = 0;
  int unsigned       quiet_cycles = 0;
  int unsigned       err_cnt = 0;
  int unsigned       gen_live = MAP_WORDS;

  always #5 clk_i = ~clk_i;

  frame_bitmap_allocator #(
    .BITMAP_WORDS(MAP_WORDS)
  ) u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we),
    .cfg_idx_i     (cfg_idx),
    .cfg_data_i    (cfg_data),
    .in_valid_i    (in_valid),
    .in_stall_o    (in_stall),
    .operation_i   (operation),
    .page_frame_i  (page_frame),
    .target_frame_i(target_frame),
    .out_valid_o   (out_valid),
    .out_stall_i   (out_stall),
    .status_o      (status),
    .frame_number_o(frame_number)
  );

  function automatic int unsigned draw_wait();
    return calm ? 0 : $urandom_range(0, 8);
  endfunction

  function automatic int unsigned live_words();
    return (words_reg > MAP_WORDS) ? MAP_WORDS : words_reg;
  endfunction

  function automatic void apply_frame_op(input frame_req_t r, output frame_res_t o);
    logic [RSV_W:0] reserved_frames;
    int unsigned    n;
    int unsigned    w;
    int unsigned    b;
    int unsigned    widx;
    bit             in_map;
    bit             hit;
    o.status = ST_DONE;
    o.frame = '0;
    n = live_words();
    case (r.op)
      OP_INIT: begin
        reserved_frames = ({1'b0, reserved_reg} + PAGE_ROUND) >> PAGE_SH;
        for (w = 0; w < MAP_WORDS; w++) begin
          if (w >= n) begin
            used_map[w] = '0;
          end else if (reserved_frames >= w * WORD_W + WORD_W) begin
            used_map[w] = '1;
          end else if (reserved_frames > w * WORD_W) begin
            used_map[w] = (32'h1 << (reserved_frames - w * WORD_W)) - 32'h1;
          end else begin
            used_map[w] = '0;
          end
        end
      end
      OP_ALLOC: begin
        if (r.page != '0) begin
          o.status = ST_SKIP;
        end else begin
          hit = 1'b0;
          for (w = 0; w < n && !hit; w++) begin
            for (b = 0; b < WORD_W && !hit; b++) begin
              if (!used_map[w][b]) begin
                hit = 1'b1;
                used_map[w][b] = 1'b1;
                o.frame = FRAME_W'(w * WORD_W + b);
              end
            end
          end
          if (!hit) o.status = ST_EMPTY;
        end
      end
      OP_ALLOC_AT: begin
        widx = r.target >> BIT_W;
        in_map = widx < n;
        if (in_map && used_map[widx][r.target[BIT_W-1:0]]) begin
          o.status = ST_SKIP;
        end else begin
          if (in_map) used_map[widx][r.target[BIT_W-1:0]] = 1'b1;
          o.frame = r.target;
        end
      end
      OP_FREE: begin
        if (r.page == '0) begin
          o.status = ST_SKIP;
        end else begin
          widx = r.page >> BIT_W;
          if (widx < n) used_map[widx][r.page[BIT_W-1:0]] = 1'b0;
          o.frame = r.page;
        end
      end
    endcase
  endfunction

  task automatic flag(input string msg);
    if (err_cnt < PRINT_LIMIT) $display("tb: mismatch at %0t: %s", $time, msg);
    err_cnt++;
  endtask

  always @(posedge clk_i) begin
    frame_res_t res;
    if (rst_ni) begin
      if (in_valid && !in_stall) begin
        apply_frame_op(cur_req, res);
        outcome_q.push_back(res);
        send_gap = draw_wait();
      end
      if (!in_valid || !in_stall) begin
        if (send_gap != 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (request_q.size() != 0) begin
          cur_req = request_q.pop_front();
          operation <= cur_req.op;
          page_frame <= cur_req.page;
          target_frame <= cur_req.target;
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    frame_res_t want;
    if (rst_ni) begin
      if (out_valid && !out_stall) begin
        if (outcome_q.size() == 0) begin
          flag($sformatf("result status %0d frame %0d with no request pending",
                         status, frame_number));
        end else begin
          want = outcome_q.pop_front();
          if (status !== want.status)
            flag($sformatf("status %0d, expected %0d (frame %0d)",
                           status, want.status, want.frame));
          if (frame_number !== want.frame)
            flag($sformatf("frame_number %0d, expected %0d", frame_number, want.frame));
        end
        take_wait = draw_wait();
      end else if (out_valid && take_wait != 0) begin
        take_wait--;
      end
      out_stall <= (take_wait != 0);
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles == QUIET_LIMIT) begin
      $display("tb: errors");
      $finish;
    end
  end

  task automatic wait_idle();
    while (request_q.size() != 0 || in_valid || outcome_q.size() != 0) @(negedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic set_config(input logic [CFG_DAT_W-1:0] words_data,
                            input logic [RSV_W-1:0] rsv);
    wait_idle();
    @(posedge clk_i);
    cfg_we <= 1'b1;
    cfg_idx <= CFG_WORDS_IN_USE;
    cfg_data <= words_data;
    @(posedge clk_i);
    cfg_idx <= CFG_RESERVED_END;
    cfg_data <= CFG_DAT_W'(rsv);
    @(posedge clk_i);
    cfg_we <= 1'b0;
    words_reg = words_data[WIU_W-1:0];
    reserved_reg = rsv;
    gen_live = live_words();
    @(negedge clk_i);
  endtask

  task automatic push(input fba_op_e kind, input logic [FRAME_W-1:0] pg,
                      input logic [FRAME_W-1:0] tg);
    request_q.push_back('{kind, pg, tg});
  endtask

  function automatic logic [FRAME_W-1:0] any_frame();
    return FRAME_W'($urandom);
  endfunction

  function automatic logic [FRAME_W-1:0] mapped_frame();
    if (gen_live == 0) return FRAME_W'($urandom_range(0, 63));
    return FRAME_W'($urandom_range(0, gen_live * WORD_W - 1));
  endfunction

  task automatic random_request();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 35) begin
      push(OP_ALLOC, '0, any_frame());
    end else if (pick < 40) begin
      push(OP_ALLOC, any_frame(), any_frame());
    end else if (pick < 60) begin
      push(OP_ALLOC_AT, any_frame(), mapped_frame());
    end else if (pick < 65) begin
      push(OP_ALLOC_AT, any_frame(), any_frame());
    end else if (pick < 87) begin
      push(OP_FREE, mapped_frame(), any_frame());
    end else if (pick < 90) begin
      push(OP_FREE, '0, any_frame());
    end else if (pick < 95) begin
      push(OP_FREE, any_frame(), any_frame());
    end else begin
      push(OP_INIT, any_frame(), any_frame());
    end
  endtask

  initial begin
    int unsigned       lw;
    int unsigned       n;
    logic [WIU_W-1:0]  w;
    logic [RSV_W-1:0]  rsv;
    for (int unsigned i = 0; i < MAP_WORDS; i++) used_map[i] = '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    set_config(32'd2, 32'h0000_2001);
    push(OP_INIT, FRAME_MAX, FRAME_MAX);
    push(OP_ALLOC, '0, FRAME_MAX);
    push(OP_ALLOC, FRAME_MAX, '0);
    push(OP_ALLOC_AT, '0, 20'd3);
    push(OP_ALLOC_AT, '0, 20'd63);
    push(OP_ALLOC_AT, FRAME_MAX, 20'd64);
    push(OP_ALLOC_AT, '0, FRAME_MAX);
    push(OP_FREE, '0, FRAME_MAX);
    push(OP_FREE, 20'd3, '0);
    push(OP_FREE, FRAME_MAX, '0);
    push(OP_ALLOC, '0, '0);

    set_config(32'hFFFF_FF01, 32'hFFFF_FFFF);
    push(OP_INIT, '0, '0);
    push(OP_ALLOC, '0, '0);
    push(OP_FREE, 20'd31, '0);
    push(OP_ALLOC, '0, '0);
    push(OP_ALLOC, '0, '0);

    set_config(32'd0, 32'h0000_1000);
    push(OP_INIT, '0, '0);
    push(OP_ALLOC, '0, '0);
    push(OP_ALLOC_AT, '0, '0);
    push(OP_FREE, 20'd5, '0);

    set_config(32'd255, 32'd0);
    push(OP_INIT, '0, '0);
    push(OP_ALLOC, '0, '0);
    push(OP_ALLOC_AT, '0, 20'd4095);
    push(OP_ALLOC_AT, '0, 20'd4096);

    for (int unsigned ph = 0; ph < 22; ph++) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4: w = WIU_W'($urandom_range(1, 4));
        5:             w = WIU_W'($urandom_range(5, 16));
        6:             w = WIU_W'($urandom_range(17, 128));
        7:             w = '0;
        8:             w = WIU_W'($urandom_range(129, 255));
        default:       w = WIU_W'(MAP_WORDS);
      endcase
      lw = (w > MAP_WORDS) ? MAP_WORDS : w;
      case ($urandom_range(0, 5))
        0:       rsv = '0;
        1:       rsv = '1;
        2, 3:    rsv = $urandom_range(0, lw * WORD_W * 4096 + 8192);
        4:       rsv = $urandom;
        default: rsv = ($urandom_range(0, 300) << PAGE_SH) + $urandom_range(0, 1);
      endcase
      calm = ($urandom_range(0, 3) == 0);
      set_config(($urandom & 32'hFFFF_FF00) | CFG_DAT_W'(w), rsv);
      if ($urandom_range(0, 9) != 0) push(OP_INIT, any_frame(), any_frame());
      n = $urandom_range(20, 36);
      repeat (n) random_request();
    end

    wait_idle();
    if (err_cnt == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule
